>>> rtl/core/pirocc_pkg.sv
package pirocc_pkg;

  localparam int unsigned CNT_W = 16;

  // phase after a tick
  typedef enum logic [1:0] {
    PH_ARMED    = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_HOLD     = 2'd2,
    PH_WAIT     = 2'd3
  } phase_t;

  // event reported with a tick
  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_MOTION   = 2'd1,
    EV_UNMOTION = 2'd2
  } event_t;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_HOLD     = 2'd1;
  localparam logic [1:0] REG_WAIT     = 2'd2;

  localparam logic [CNT_W-1:0] DEBOUNCE_RST = 16'd200;
  localparam logic [CNT_W-1:0] HOLD_RST     = 16'd5000;
  localparam logic [CNT_W-1:0] WAIT_RST     = 16'd30000;

  typedef struct packed {
    phase_t           phase;
    logic [CNT_W-1:0] countdown;
    logic             running;
    logic             last_level;
  } det_state_t;

  // a duration of zero counts as one tick
  function automatic logic [CNT_W-1:0] load_value(input logic [CNT_W-1:0] ms);
    load_value = (ms == '0) ? CNT_W'(1) : ms;
  endfunction

endpackage

>>> rtl/core/pir_motion_occupancy_detector_core.sv
// channel   direction  handshake              payload
// in_       request in in_valid / in_stall    in_pin_level
// out_      result out out_valid / out_stall  out_event_res, out_phase
// config    apb write  psel/penable/pwrite    paddr[3:0], pwdata[15:0]
//
// one tick accepted every clock unless in_stall; the result reaches out_ via the
// input register, then the detector step into the result register
// active-low sync reset clears phase, counter, edge history; sets timing defaults
// a stalled result holds in the output register while one more tick waits in
// the input register; in_stall rises only when both are full
module pir_motion_occupancy_detector_core (
  input  logic        clk,
  input  logic        rst_n,
  // tick requests
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_pin_level,
  // results
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_res,
  output logic [1:0]  out_phase,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // timing registers
  logic [pirocc_pkg::CNT_W-1:0] debounce_ms_r;
  logic [pirocc_pkg::CNT_W-1:0] hold_ms_r;
  logic [pirocc_pkg::CNT_W-1:0] wait_ms_r;

  // input stage
  logic s1_valid_r;
  logic s1_level_r;

  // detector state, advanced once per tick as it moves into the result register
  pirocc_pkg::det_state_t state_r;
  pirocc_pkg::det_state_t state_nxt;
  pirocc_pkg::event_t     event_nxt;

  // result register
  logic              out_valid_r;
  logic [1:0]        out_event_res_r;
  logic [1:0]        out_phase_r;

  logic out_load;
  logic s1_take;
  logic cfg_wr;

  assign out_load = s1_valid_r && (!out_valid_r || !out_stall);
  assign s1_take  = !s1_valid_r || out_load;
  assign in_stall = !s1_take;

  assign out_valid     = out_valid_r;
  assign out_event_res = out_event_res_r;
  assign out_phase     = out_phase_r;

  pirocc_step u_step (
    .state       (state_r),
    .level       (s1_level_r),
    .debounce_ms (debounce_ms_r),
    .hold_ms     (hold_ms_r),
    .wait_ms     (wait_ms_r),
    .state_nxt   (state_nxt),
    .event_res   (event_nxt)
  );

  // control state and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r           <= 1'b0;
      out_valid_r          <= 1'b0;
      state_r.phase        <= pirocc_pkg::PH_ARMED;
      state_r.countdown    <= '0;
      state_r.running      <= 1'b0;
      state_r.last_level   <= 1'b0;
      debounce_ms_r        <= pirocc_pkg::DEBOUNCE_RST;
      hold_ms_r            <= pirocc_pkg::HOLD_RST;
      wait_ms_r            <= pirocc_pkg::WAIT_RST;
    end else begin
      if (s1_take) begin
        s1_valid_r <= in_valid;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        case (paddr[3:2])
          pirocc_pkg::REG_DEBOUNCE: debounce_ms_r <= pwdata[pirocc_pkg::CNT_W-1:0];
          pirocc_pkg::REG_HOLD:     hold_ms_r     <= pwdata[pirocc_pkg::CNT_W-1:0];
          pirocc_pkg::REG_WAIT:     wait_ms_r     <= pwdata[pirocc_pkg::CNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_level_r <= in_pin_level;
    end
    if (out_load) begin
      out_event_res_r <= event_nxt;
      out_phase_r     <= state_nxt.phase;
    end
  end

  // apb access, always ready
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      pirocc_pkg::REG_DEBOUNCE: prdata = {16'd0, debounce_ms_r};
      pirocc_pkg::REG_HOLD:     prdata = {16'd0, hold_ms_r};
      pirocc_pkg::REG_WAIT:     prdata = {16'd0, wait_ms_r};
      default:                  prdata = '0;
    endcase
  end

endmodule

>>> rtl/core/pirocc_step.sv
module pirocc_step (
  input  pirocc_pkg::det_state_t          state,
  input  logic                            level,
  input  logic [pirocc_pkg::CNT_W-1:0]    debounce_ms,
  input  logic [pirocc_pkg::CNT_W-1:0]    hold_ms,
  input  logic [pirocc_pkg::CNT_W-1:0]    wait_ms,
  output pirocc_pkg::det_state_t          state_nxt,
  output pirocc_pkg::event_t              event_res
);

  logic [pirocc_pkg::CNT_W-1:0] cnt_dec;
  logic                         expire;

  assign cnt_dec = state.countdown - pirocc_pkg::CNT_W'(1);
  assign expire  = state.running && (cnt_dec == '0);

  always_comb begin
    state_nxt            = state;
    state_nxt.last_level = level;
    event_res            = pirocc_pkg::EV_NONE;

    // timer step first
    if (state.running) begin
      state_nxt.countdown = cnt_dec;
    end
    if (expire) begin
      state_nxt.running = 1'b0;
      case (state.phase)
        pirocc_pkg::PH_DEBOUNCE: begin
          if (level) begin
            event_res           = pirocc_pkg::EV_MOTION;
            state_nxt.phase     = pirocc_pkg::PH_HOLD;
            state_nxt.countdown = pirocc_pkg::load_value(hold_ms);
            state_nxt.running   = 1'b1;
          end else begin
            state_nxt.phase = pirocc_pkg::PH_ARMED;
          end
        end
        pirocc_pkg::PH_HOLD: begin
          state_nxt.phase     = pirocc_pkg::PH_WAIT;
          state_nxt.countdown = pirocc_pkg::load_value(wait_ms);
          state_nxt.running   = 1'b1;
        end
        pirocc_pkg::PH_WAIT: begin
          event_res = pirocc_pkg::EV_UNMOTION;
        end
        default: begin
        end
      endcase
    end

    // edge detection on the phase left by the timer step
    if ((state_nxt.phase == pirocc_pkg::PH_ARMED || state_nxt.phase == pirocc_pkg::PH_WAIT)
        && level && !state.last_level) begin
      state_nxt.phase     = pirocc_pkg::PH_DEBOUNCE;
      state_nxt.countdown = pirocc_pkg::load_value(debounce_ms);
      state_nxt.running   = 1'b1;
    end
  end

endmodule

>>> rtl/core/pirocc_chk.sv
module pirocc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_event_res,
  input logic [1:0]  out_phase
);

  // input side only backs up when the result side is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result side free");

  // a stalled result keeps its fields
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_event_res) && $stable(out_phase)))
    else $error("stalled result changed");

  // motion always leaves the block in hold
  a_motion_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_res == pirocc_pkg::EV_MOTION) |-> (out_phase == pirocc_pkg::PH_HOLD))
    else $error("motion reported outside hold");

  // unmotion only from wait, or debounce when a new edge arrives on the same tick
  a_unmotion_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_res == pirocc_pkg::EV_UNMOTION) |->
      (out_phase == pirocc_pkg::PH_WAIT || out_phase == pirocc_pkg::PH_DEBOUNCE))
    else $error("unmotion reported in wrong phase");

endmodule

bind pir_motion_occupancy_detector_core pirocc_chk u_pirocc_chk (.*);

>>> sim/pir_motion_occupancy_detector_core_tb.sv
`timescale 1ns / 1ps

module pir_motion_occupancy_detector_core_tb;

  localparam int CLK_HALF           = 10;
  localparam int RESET_CYCLES       = 9;
  // covers the input and result registers plus a little margin before registers are touched
  localparam int RESULT_LATENCY     = 2;
  localparam int SETTLE_CYCLES      = RESULT_LATENCY + 3;
  // watchdog limit on the whole run
  localparam int CYCLE_LIMIT        = 200000;
  localparam int ROUND_TICKS        = 280;
  localparam int HOLD_OFF_CYCLES    = 80;

  // how the result side stalls over a stretch of cycles
  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_pattern_t;

  // what one tick should report
  typedef struct packed {
    pirocc_pkg::event_t ev;
    pirocc_pkg::phase_t ph;
  } tick_report_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_pin_level;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_event_res;
  logic [1:0]  out_phase;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pir_motion_occupancy_detector_core uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pin_level  (in_pin_level),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_event_res (out_event_res),
    .out_phase     (out_phase),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // detector mirror: phase, millisecond counter, edge history and durations
  pirocc_pkg::phase_t           det_phase;
  logic [pirocc_pkg::CNT_W-1:0] det_count;
  logic                         det_running;
  logic                         det_last;
  logic [pirocc_pkg::CNT_W-1:0] debounce_cfg;
  logic [pirocc_pkg::CNT_W-1:0] hold_cfg;
  logic [pirocc_pkg::CNT_W-1:0] wait_cfg;

  // reports still owed by the block, oldest first
  tick_report_t awaited_reports[$];

  int mismatches  = 0;
  int cycle_count = 0;

  // sender burst control
  int burst_left    = 0;
  bit sender_bursty = 1'b1;

  // receiver stall control; a hold-off request is picked up by the stall process
  int             hold_off_req  = 0;
  int             hold_off_left = 0;
  int             mode_left     = 0;
  int             stall_phase   = 0;
  bit             recv_steady   = 1'b0;
  stall_pattern_t stall_mode    = STALL_NONE;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // a zero duration still takes one tick
  function automatic void arm_timer(input logic [pirocc_pkg::CNT_W-1:0] ms);
    det_count   = (ms == '0) ? pirocc_pkg::CNT_W'(1) : ms;
    det_running = 1'b1;
  endfunction

  // one millisecond tick: timer first, then edge detection on the new phase,
  // edge history last
  function automatic tick_report_t advance_detector(input logic level);
    tick_report_t rep;
    rep.ev = pirocc_pkg::EV_NONE;
    if (det_running) begin
      det_count = det_count - 1'b1;
      if (det_count == '0) begin
        det_running = 1'b0;
        case (det_phase)
          pirocc_pkg::PH_DEBOUNCE: begin
            if (level) begin
              rep.ev    = pirocc_pkg::EV_MOTION;
              det_phase = pirocc_pkg::PH_HOLD;
              arm_timer(hold_cfg);
            end else begin
              det_phase = pirocc_pkg::PH_ARMED;
            end
          end
          pirocc_pkg::PH_HOLD: begin
            det_phase = pirocc_pkg::PH_WAIT;
            arm_timer(wait_cfg);
          end
          pirocc_pkg::PH_WAIT: begin
            // occupancy timed out; timer stays stopped, edges stay enabled
            rep.ev = pirocc_pkg::EV_UNMOTION;
          end
          default: ;
        endcase
      end
    end
    // an edge in wait cancels the pending timeout
    if ((det_phase == pirocc_pkg::PH_ARMED || det_phase == pirocc_pkg::PH_WAIT)
        && level && !det_last) begin
      det_phase = pirocc_pkg::PH_DEBOUNCE;
      arm_timer(debounce_cfg);
    end
    det_last = level;
    rep.ph   = det_phase;
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
  endtask

  // every result taken by the receiver is held against the oldest report owed
  always @(posedge clk) begin : check_reports
    tick_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_reports.size() == 0) begin
        // -1 stands for no report owed at all
        note_mismatch("unrequested result event", -1, out_event_res);
      end else begin
        want = awaited_reports.pop_front();
        if (out_event_res !== want.ev) note_mismatch("event", want.ev, out_event_res);
        if (out_phase !== want.ph) note_mismatch("phase", want.ph, out_phase);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL pir_motion_occupancy_detector_core");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // result side stalls
  // ---------------------------------------------------------------------------

  // a random stall pattern, picked anew when its run ends; a hold-off or a steady receiver overrides it
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      out_stall <= 1'b1;
      hold_off_left = hold_off_left - 1;
    end else if (hold_off_req > 0) begin
      out_stall <= 1'b1;
      hold_off_left = hold_off_req - 1;
      hold_off_req  = 0;
    end else if (recv_steady) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_pattern_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(30, 150);
      end else begin
        mode_left = mode_left - 1;
      end
      stall_phase = stall_phase + 1;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ((stall_phase % 5) < 2);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // request and register access
  // ---------------------------------------------------------------------------

  // one tick request; gaps between bursts carry junk levels with valid low
  task automatic send_tick(input logic level);
    int gap;
    if (sender_bursty && burst_left == 0) begin
      gap        = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 24);
      repeat (gap) begin
        @(negedge clk);
        in_valid     <= 1'b0;
        in_pin_level <= 1'($urandom_range(0, 1));
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_pin_level <= level;
    do @(posedge clk); while (in_stall);
    awaited_reports.push_back(advance_detector(level));
  endtask

  // stop offering and let every owed report come back
  task automatic drain_reports();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup cycle then access cycle
  task automatic apb_transfer(input logic wr, input logic [1:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_register(input logic [1:0] idx,
                                input logic [pirocc_pkg::CNT_W-1:0] want);
    logic [31:0] rd;
    apb_transfer(1'b0, idx, '0, rd);
    if (rd[pirocc_pkg::CNT_W-1:0] !== want)
      note_mismatch("register readback", want, rd[pirocc_pkg::CNT_W-1:0]);
  endtask

  // only the low half of the word is kept
  task automatic set_register(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] rd;
    apb_transfer(1'b1, idx, value, rd);
    case (idx)
      pirocc_pkg::REG_DEBOUNCE: debounce_cfg = value[pirocc_pkg::CNT_W-1:0];
      pirocc_pkg::REG_HOLD:     hold_cfg     = value[pirocc_pkg::CNT_W-1:0];
      default:                  wait_cfg     = value[pirocc_pkg::CNT_W-1:0];
    endcase
    check_register(idx, value[pirocc_pkg::CNT_W-1:0]);
  endtask

  // short random durations so every phase comes round often; junk in the top half
  task automatic pick_short_durations();
    set_register(pirocc_pkg::REG_DEBOUNCE, {16'($urandom), 16'($urandom_range(0, 12))});
    set_register(pirocc_pkg::REG_HOLD,     {16'($urandom), 16'($urandom_range(1, 30))});
    set_register(pirocc_pkg::REG_WAIT,     {16'($urandom), 16'($urandom_range(1, 40))});
  endtask

  // pin activity as runs of high and low: short runs that fail debounce,
  // long runs that reach motion and sit out hold and wait, some glitches
  task automatic random_ticks(input int n);
    int   run_left;
    int   d_ms;
    int   h_ms;
    int   w_ms;
    logic lvl;
    d_ms     = debounce_cfg;
    h_ms     = hold_cfg;
    w_ms     = wait_cfg;
    run_left = 0;
    lvl      = 1'($urandom_range(0, 1));
    for (int k = 0; k < n; k++) begin
      if (run_left == 0) begin
        lvl = ~lvl;
        case ($urandom_range(0, 9))
          0:       run_left = 1;
          1, 2, 3: run_left = $urandom_range(1, d_ms + 1);
          default: run_left = $urandom_range(d_ms, d_ms + h_ms + w_ms + 3);
        endcase
        if (run_left > 120) run_left = $urandom_range(20, 120);
        if (run_left < 1) run_left = 1;
      end
      run_left--;
      if ($urandom_range(0, 19) == 0) send_tick(1'($urandom_range(0, 1)));
      else send_tick(lvl);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_register_defaults();
    check_register(pirocc_pkg::REG_DEBOUNCE, pirocc_pkg::DEBOUNCE_RST);
    check_register(pirocc_pkg::REG_HOLD, pirocc_pkg::HOLD_RST);
    check_register(pirocc_pkg::REG_WAIT, pirocc_pkg::WAIT_RST);
  endtask

  // edge history starts low, so a high first tick is a rising edge;
  // zero durations go in first so the run does not sit out the defaults
  task automatic test_first_tick_edge();
    set_register(pirocc_pkg::REG_DEBOUNCE, 32'd0);
    set_register(pirocc_pkg::REG_HOLD, 32'd0);
    set_register(pirocc_pkg::REG_WAIT, 32'd0);
    send_tick(1'b1);
  endtask

  // every timer lasts one tick: motion, hold, wait, unmotion together with an
  // edge in wait, a failed debounce, and unmotion followed by silence
  task automatic test_zero_durations();
    logic [11:0] levels;
    levels = 12'b1010_0111_1100;
    for (int k = 11; k >= 0; k--) send_tick(levels[k]);
  endtask

  // a register written mid-timing only counts at the next load
  task automatic test_write_while_timing();
    drain_reports();
    set_register(pirocc_pkg::REG_DEBOUNCE, 32'd4);
    set_register(pirocc_pkg::REG_HOLD, 32'd3);
    set_register(pirocc_pkg::REG_WAIT, 32'd5);
    send_tick(1'b1);
    send_tick(1'b1);
    drain_reports();
    set_register(pirocc_pkg::REG_HOLD, 32'd6);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    drain_reports();
    // largest values, never loaded before the next rewrite
    set_register(pirocc_pkg::REG_DEBOUNCE, 32'hffff_ffff);
    set_register(pirocc_pkg::REG_HOLD, 32'h0000_ffff);
  endtask

  // shortest durations, both sides running flat out
  task automatic test_minimum_durations();
    drain_reports();
    set_register(pirocc_pkg::REG_DEBOUNCE, 32'd1);
    set_register(pirocc_pkg::REG_HOLD, 32'd1);
    set_register(pirocc_pkg::REG_WAIT, 32'd1);
    sender_bursty = 1'b0;
    recv_steady   = 1'b1;
    random_ticks(ROUND_TICKS);
    sender_bursty = 1'b1;
    recv_steady   = 1'b0;
  endtask

  task automatic test_random_durations();
    repeat (2) begin
      drain_reports();
      pick_short_durations();
      random_ticks(ROUND_TICKS);
    end
  endtask

  // receiver holds off while ticks keep coming, so the pipeline fills
  task automatic test_input_backpressure();
    drain_reports();
    pick_short_durations();
    random_ticks(60);
    hold_off_req = HOLD_OFF_CYCLES;
    random_ticks(ROUND_TICKS - 60);
  endtask

  // sender stops mid-stream until every report is back, then carries on
  task automatic test_sender_pause();
    drain_reports();
    pick_short_durations();
    random_ticks(ROUND_TICKS / 2);
    drain_reports();
    random_ticks(ROUND_TICKS - ROUND_TICKS / 2);
  endtask

  // longest wait: only fresh edges ever get out of it
  task automatic test_long_wait();
    drain_reports();
    set_register(pirocc_pkg::REG_DEBOUNCE, {16'($urandom), 16'($urandom_range(1, 3))});
    set_register(pirocc_pkg::REG_HOLD, {16'($urandom), 16'($urandom_range(1, 4))});
    set_register(pirocc_pkg::REG_WAIT, 32'h0000_ffff);
    random_ticks(ROUND_TICKS);
  endtask

  // longest hold: once motion is seen, edges are ignored for the rest of the run
  task automatic test_long_hold();
    drain_reports();
    set_register(pirocc_pkg::REG_DEBOUNCE, 32'd2);
    set_register(pirocc_pkg::REG_HOLD, 32'h0000_ffff);
    set_register(pirocc_pkg::REG_WAIT, 32'h0000_ffff);
    random_ticks(ROUND_TICKS / 2);
  endtask

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_pin_level = 1'b0;
    out_stall    = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;

    det_phase    = pirocc_pkg::PH_ARMED;
    det_count    = '0;
    det_running  = 1'b0;
    det_last     = 1'b0;
    debounce_cfg = pirocc_pkg::DEBOUNCE_RST;
    hold_cfg     = pirocc_pkg::HOLD_RST;
    wait_cfg     = pirocc_pkg::WAIT_RST;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_register_defaults();
    test_first_tick_edge();
    test_zero_durations();
    test_write_while_timing();
    test_minimum_durations();
    test_random_durations();
    test_input_backpressure();
    test_sender_pause();
    test_long_wait();
    test_long_hold();

    drain_reports();
    if (mismatches == 0) begin
      $display("PASS pir_motion_occupancy_detector_core");
    end else begin
      $display("FAIL pir_motion_occupancy_detector_core");
    end
    $finish;
  end

endmodule

>>> pir_motion_occupancy_detector_core.f
rtl/core/pirocc_pkg.sv
rtl/core/pirocc_step.sv
rtl/core/pir_motion_occupancy_detector_core.sv
rtl/core/pirocc_chk.sv
sim/pir_motion_occupancy_detector_core_tb.sv
